[src/cor_pkg.sv]
// Shared types and constants of the circle outline rasterizer.
// Used by every module of the block; depends on nothing.
package cor_pkg;

  localparam int RADIUS_BITS = 12;
  localparam int COORD_BITS  = 16;
  localparam int SQ_BITS     = 2 * RADIUS_BITS;
  localparam int ROOT_CNT_W  = $clog2(RADIUS_BITS);

  localparam int SYM_PIXELS  = 8;
  localparam int QUART_PIXELS = 4;
  localparam int PIX_IDX_W   = $clog2(SYM_PIXELS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  typedef struct packed {
    logic                   mode;
    logic [COORD_BITS-1:0]  x_center;
    logic [COORD_BITS-1:0]  y_center;
    logic [RADIUS_BITS-1:0] radius;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  circle_last;
  } out_item_t;

  // Which pixels of the eight-way pattern a group emits.
  typedef enum logic [1:0] {
    KIND_AXIS = 2'd0,
    KIND_DIAG = 2'd1,
    KIND_SYM  = 2'd2
  } kind_t;

  // One group of pixels handed from the front end to the pixel emitter.
  typedef struct packed {
    kind_t                  kind;
    logic [COORD_BITS-1:0]  x_center;
    logic [COORD_BITS-1:0]  y_center;
    logic [RADIUS_BITS-1:0] col;
    logic [RADIUS_BITS-1:0] row;
    logic                   last;
  } cmd_t;

endpackage

[src/cor_front.sv]
// Front end: accepts items, holds the circle state and runs the rounded root.
// Depends on cor_pkg; feeds pixel groups into cor_queue.
module cor_front import cor_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  output logic     cmd_push,
  output cmd_t     cmd,
  input  logic     cmd_full
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_SUB   = 6'b000100,
    S_ROOT  = 6'b001000,
    S_ROUND = 6'b010000,
    S_PUSH  = 6'b100000
  } state_t;

  state_t                 state;
  logic [COORD_BITS-1:0]  center_col;
  logic [COORD_BITS-1:0]  center_row;
  logic [SQ_BITS-1:0]     radius_squared;
  logic [RADIUS_BITS-1:0] step_col;
  logic [RADIUS_BITS-1:0] step_row;
  logic                   drawing_active;

  logic [RADIUS_BITS-1:0] new_col;
  logic [SQ_BITS-1:0]     col_sq;
  logic [SQ_BITS-1:0]     root_rem;
  logic [SQ_BITS-1:0]     root_res;
  logic [SQ_BITS-1:0]     root_bit;
  logic [ROOT_CNT_W-1:0]  root_cnt;
  cmd_t                   pend_cmd;

  logic                   accept;
  logic                   is_start;
  logic [RADIUS_BITS-1:0] r;
  logic [RADIUS_BITS-1:0] start_row;
  logic                   start_diag;
  logic                   start_sym;
  cmd_t                   start_cmd;
  cmd_t                   diag_cmd;
  logic [SQ_BITS-1:0]     trial;
  logic [RADIUS_BITS-1:0] floor_s;
  logic [RADIUS_BITS-1:0] new_row;
  logic                   new_last;

  assign full     = (state != S_IDLE) || cmd_full;
  assign accept   = push && !full;
  assign is_start = (item.mode == MODE_START);
  assign r        = item.radius;

  // round(sqrt(r*r - 1)) is r itself for every radius of two or more, and zero below.
  assign start_row  = (r >= RADIUS_BITS'(2)) ? r : '0;
  assign start_diag = accept && !is_start && drawing_active && (step_col == step_row);
  assign start_sym  = accept && !is_start && drawing_active && (step_col < step_row);

  always_comb begin
    start_cmd.kind     = KIND_AXIS;
    start_cmd.x_center = item.x_center;
    start_cmd.y_center = item.y_center;
    start_cmd.col      = '0;
    start_cmd.row      = r;
    start_cmd.last     = (start_row == '0);

    diag_cmd.kind     = KIND_DIAG;
    diag_cmd.x_center = center_col;
    diag_cmd.y_center = center_row;
    diag_cmd.col      = step_col;
    diag_cmd.row      = step_row;
    diag_cmd.last     = 1'b1;
  end

  always_comb begin
    cmd_push = 1'b0;
    cmd      = pend_cmd;
    priority if (accept && is_start) begin
      cmd_push = 1'b1;
      cmd      = start_cmd;
    end else if (start_diag) begin
      cmd_push = 1'b1;
      cmd      = diag_cmd;
    end else if (state == S_PUSH) begin
      cmd_push = !cmd_full;
    end else begin
      cmd_push = 1'b0;
    end
  end

  assign trial    = root_res + root_bit;
  assign floor_s  = root_res[RADIUS_BITS-1:0];
  assign new_row  = floor_s + RADIUS_BITS'(root_rem > SQ_BITS'(floor_s));
  assign new_last = (new_col > new_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      center_col     <= '0;
      center_row     <= '0;
      radius_squared <= '0;
      step_col       <= '0;
      step_row       <= '0;
      drawing_active <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_start) begin
              center_col     <= item.x_center;
              center_row     <= item.y_center;
              radius_squared <= SQ_BITS'(r) * SQ_BITS'(r);
              step_col       <= RADIUS_BITS'(1);
              step_row       <= start_row;
              drawing_active <= (start_row != '0);
            end else if (start_sym) begin
              new_col <= step_col + RADIUS_BITS'(1);
              state   <= S_MUL;
            end else if (drawing_active) begin
              // The diagonal group, or a column past the row, ends the circle.
              drawing_active <= 1'b0;
            end
          end
        end
        S_MUL: begin
          col_sq <= SQ_BITS'(new_col) * SQ_BITS'(new_col);
          state  <= S_SUB;
        end
        S_SUB: begin
          root_rem <= (col_sq > radius_squared) ? '0 : radius_squared - col_sq;
          root_res <= '0;
          root_bit <= SQ_BITS'(1) << (SQ_BITS - 2);
          root_cnt <= '0;
          state    <= S_ROOT;
        end
        S_ROOT: begin
          if (root_rem >= trial) begin
            root_rem <= root_rem - trial;
            root_res <= (root_res >> 1) + root_bit;
          end else begin
            root_res <= root_res >> 1;
          end
          root_bit <= root_bit >> 2;
          root_cnt <= root_cnt + ROOT_CNT_W'(1);
          if (root_cnt == ROOT_CNT_W'(RADIUS_BITS - 1)) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          pend_cmd.kind     <= KIND_SYM;
          pend_cmd.x_center <= center_col;
          pend_cmd.y_center <= center_row;
          pend_cmd.col      <= step_col;
          pend_cmd.row      <= step_row;
          pend_cmd.last     <= new_last;
          step_col          <= new_col;
          step_row          <= new_row;
          if (new_last) begin
            drawing_active <= 1'b0;
          end
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (!cmd_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_active_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && drawing_active) |-> (step_col <= step_row))
    else $error("active circle with column beyond row");

  a_root_bit: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROOT) |-> $onehot(root_bit))
    else $error("root trial bit lost during iteration");

endmodule

[src/cor_queue.sv]
// Short queue of pixel groups between the front end and the pixel emitter.
// Depends on cor_pkg for the group type and depth.
module cor_queue import cor_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd,
  output cmd_t rd_data,
  output logic empty
);

  cmd_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_wr;
  logic                   do_rd;

  assign full    = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QUEUE_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QUEUE_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr && full))
    else $error("pixel group written into a full queue");

endmodule

[src/cor_back.sv]
// Back end: expands each pixel group into single pixels, one per cycle unless pop stalls.
// Depends on cor_pkg; reads groups from cor_queue and drives the result register.
module cor_back import cor_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  output logic      q_rd,
  input  cmd_t      q_data,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  cmd_t                 cur;
  logic                 cur_valid;
  logic [PIX_IDX_W-1:0] step;
  logic                 out_valid;

  logic                  out_free;
  logic                  last_step;
  logic                  emit;
  logic                  finishing;
  logic                  load;
  logic [PIX_IDX_W-1:0]  idx;
  logic [COORD_BITS-1:0] xo;
  logic [COORD_BITS-1:0] yo;
  out_item_t             pix;

  // Position in the eight-way pattern; the axis group uses entries 0, 1, 4 and 7
  // with column zero.
  function automatic logic [PIX_IDX_W-1:0] pattern_index(kind_t kind,
                                                         logic [PIX_IDX_W-1:0] s);
    logic [PIX_IDX_W-1:0] v;
    v = s;
    if (kind == KIND_AXIS) begin
      unique case (s)
        PIX_IDX_W'(2): v = PIX_IDX_W'(4);
        PIX_IDX_W'(3): v = PIX_IDX_W'(7);
        default:       v = s;
      endcase
    end
    return v;
  endfunction

  assign out_free  = !out_valid || pop;
  assign last_step = (cur.kind == KIND_SYM) ? (step == PIX_IDX_W'(SYM_PIXELS - 1))
                                            : (step == PIX_IDX_W'(QUART_PIXELS - 1));
  assign emit      = cur_valid && out_free;
  assign finishing = emit && last_step;
  assign load      = !q_empty && (!cur_valid || finishing);
  assign q_rd      = load;
  assign empty     = !out_valid;

  assign idx = pattern_index(cur.kind, step);
  assign xo  = COORD_BITS'(cur.col);
  assign yo  = COORD_BITS'(cur.row);

  always_comb begin
    pix.circle_last = cur.last && last_step;
    unique case (idx)
      3'd0: begin pix.pixel_x = cur.x_center + xo; pix.pixel_y = cur.y_center + yo; end
      3'd1: begin pix.pixel_x = cur.x_center + xo; pix.pixel_y = cur.y_center - yo; end
      3'd2: begin pix.pixel_x = cur.x_center - xo; pix.pixel_y = cur.y_center + yo; end
      3'd3: begin pix.pixel_x = cur.x_center - xo; pix.pixel_y = cur.y_center - yo; end
      3'd4: begin pix.pixel_x = cur.x_center + yo; pix.pixel_y = cur.y_center + xo; end
      3'd5: begin pix.pixel_x = cur.x_center + yo; pix.pixel_y = cur.y_center - xo; end
      3'd6: begin pix.pixel_x = cur.x_center - yo; pix.pixel_y = cur.y_center + xo; end
      default: begin pix.pixel_x = cur.x_center - yo; pix.pixel_y = cur.y_center - xo; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (out_free) begin
        out_valid <= cur_valid;
      end
      if (load) begin
        cur_valid <= 1'b1;
        step      <= '0;
      end else if (finishing) begin
        cur_valid <= 1'b0;
      end else if (emit) begin
        step <= step + PIX_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= pix;
    end
    if (load) begin
      cur <= q_data;
    end
  end

  a_short_group: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && cur.kind != KIND_SYM) |-> (step < PIX_IDX_W'(QUART_PIXELS)))
    else $error("four-pixel group ran past its fourth pixel");

endmodule

[src/circle_outline_rasterizer_top.sv]
// Circle outline rasterizer: eight-way symmetric outline pixels, at most a group per item.
// Depends on cor_pkg, cor_front, cor_queue and cor_back.
//
// Input channel: an item is taken at a clock edge with push high and full low.
// A start item (mode 0) latches center and radius and queues the four axis
// pixels and leaves the front end idle, so another item may follow right away. An
// advance item (mode 1) that takes a symmetric step computes the next row with an
// exact rounded square root, one result bit per cycle; full stays high through
// the square, subtract, 12 root steps, rounding and queue write, the last of which
// queues the eight pixels once the queue has room. The advance that reaches the
// diagonal queues its four pixels at once, and an advance after the circle has
// ended gives no pixels; both leave the front end idle.
// Result channel: a pixel waits in the output register while empty is low and
// is taken at an edge with pop high. The pixel emitter sends one pixel per cycle
// while pop keeps the output register free; a group moves from its queue slot to
// the group register first; a short group queue lets the root run as earlier pixels drain.
// When the receiver stalls, the queue fills and full holds the input off; nothing is dropped.
// Reset (rst, synchronous) empties the queue and output and idles the circle.
module circle_outline_rasterizer_top import cor_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic q_wr;
  cmd_t q_wr_data;
  logic q_full;
  logic q_rd;
  cmd_t q_rd_data;
  logic q_empty;

  cor_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .cmd_push (q_wr),
    .cmd      (q_wr_data),
    .cmd_full (q_full)
  );

  cor_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  cor_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .q_data  (q_rd_data),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
